// ----- sv/cdlr_pkg.sv -----
// cdlr_pkg: widths, codes and command/status types of the line rasterizer
// used by cdlr_ctrl, cdlr_datapath and clipped_dda_line_rasterizer_unit
package cdlr_pkg;

    localparam int COORD_BITS  = 16;
    localparam int ADDR_BITS   = 24;
    localparam int REG_BITS    = 13;
    localparam int COLOUR_BITS = 32;
    localparam int CFG_IDX_BITS = 2;

    localparam int CMP_BITS  = (COORD_BITS > REG_BITS) ? COORD_BITS : REG_BITS;
    localparam int PROD_BITS = COORD_BITS + REG_BITS;
    localparam int SUM_BITS  = PROD_BITS + 1;

    localparam logic [REG_BITS-1:0] WIDTH_RESET  = REG_BITS'(640);
    localparam logic [REG_BITS-1:0] HEIGHT_RESET = REG_BITS'(480);

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    localparam logic [CFG_IDX_BITS-1:0] CFG_WIDTH  = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] CFG_HEIGHT = CFG_IDX_BITS'(1);

    typedef struct packed {
        logic load;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic last;
    } t_stat;

endpackage

// ----- sv/cdlr_ctrl.sv -----
// cdlr_ctrl: line state machine and handshake control of the rasterizer
// depends on cdlr_pkg; drives cdlr_datapath through t_cmd
module cdlr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_kind,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output cdlr_pkg::t_cmd    o_cmd,
    input  cdlr_pkg::t_stat   i_stat
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_DRAW = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_accept;

    assign o_in_stall  = r_out_valid & i_out_stall;
    assign w_accept    = i_in_valid & ~o_in_stall;
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd.load = w_accept & (i_kind == cdlr_pkg::KIND_LOAD);
        o_cmd.emit = 1'b0;
        n_state    = r_state;
        case (r_state)
            ST_IDLE: begin
                if (o_cmd.load) begin
                    n_state = ST_DRAW;
                end
            end
            ST_DRAW: begin
                o_cmd.emit = w_accept & (i_kind == cdlr_pkg::KIND_TICK);
                if (o_cmd.emit & i_stat.last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        if (o_cmd.emit) begin
            n_out_valid = 1'b1;
        end else begin
            n_out_valid = r_out_valid & i_out_stall;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

`ifndef ASSERT_OFF
    a_emit_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |=> r_out_valid)
        else $error("emitted word not presented");
    a_no_emit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !o_cmd.emit)
        else $error("word emitted with no line active");
    a_last_ends_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit && i_stat.last) |=> (r_state == ST_IDLE))
        else $error("line still active after last point");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> (!o_cmd.emit && !o_cmd.load))
        else $error("command issued while output word is held");
`endif

endmodule

// ----- sv/cdlr_datapath.sv -----
// cdlr_datapath: line registers, quotient/remainder stepping, clip and address
// depends on cdlr_pkg; commanded by cdlr_ctrl
module cdlr_datapath (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  cdlr_pkg::t_cmd                        i_cmd,
    output cdlr_pkg::t_stat                       o_stat,
    input  logic                                  i_cfg_we,
    input  logic [cdlr_pkg::CFG_IDX_BITS-1:0]     i_cfg_idx,
    input  logic [cdlr_pkg::REG_BITS-1:0]         i_cfg_data,
    input  logic signed [cdlr_pkg::COORD_BITS-1:0] i_start_x,
    input  logic signed [cdlr_pkg::COORD_BITS-1:0] i_start_y,
    input  logic signed [cdlr_pkg::COORD_BITS-1:0] i_end_x,
    input  logic signed [cdlr_pkg::COORD_BITS-1:0] i_end_y,
    input  logic [cdlr_pkg::COLOUR_BITS-1:0]      i_line_colour,
    output logic signed [cdlr_pkg::COORD_BITS-1:0] o_pixel_x,
    output logic signed [cdlr_pkg::COORD_BITS-1:0] o_pixel_y,
    output logic [cdlr_pkg::ADDR_BITS-1:0]        o_pixel_address,
    output logic [cdlr_pkg::COLOUR_BITS-1:0]      o_pixel_value,
    output logic                                  o_inside_res,
    output logic                                  o_last
);

    localparam int CB = cdlr_pkg::COORD_BITS;

    logic [cdlr_pkg::REG_BITS-1:0]    r_width, r_height;
    logic [CB-1:0]                    r_cur_x, r_cur_y, n_cur_x, n_cur_y;
    logic [CB-1:0]                    r_abs_dx, r_abs_dy;
    logic                             r_neg_x, r_neg_y;
    logic [CB-1:0]                    r_rem_x, r_rem_y, n_rem_x, n_rem_y;
    logic [CB-1:0]                    r_span, r_step;
    logic [cdlr_pkg::COLOUR_BITS-1:0] r_colour;

    logic [CB:0]                      w_dx, w_dy, w_ax, w_ay;
    logic [CB:0]                      w_sum_x, w_sum_y, w_dif_x, w_dif_y;
    logic                             w_carry_x, w_carry_y;
    logic                             w_in_x, w_in_y, w_inside;
    logic [cdlr_pkg::PROD_BITS-1:0]   w_prod;
    logic [cdlr_pkg::SUM_BITS-1:0]    w_addr_sum;

    // load: deltas, magnitudes and span
    assign w_dx = {i_end_x[CB-1], i_end_x} - {i_start_x[CB-1], i_start_x};
    assign w_dy = {i_end_y[CB-1], i_end_y} - {i_start_y[CB-1], i_start_y};
    assign w_ax = w_dx[CB] ? -w_dx : w_dx;
    assign w_ay = w_dy[CB] ? -w_dy : w_dy;

    // step: remainder of i*|d|/span, carry moves the coordinate by one
    assign w_sum_x   = {1'b0, r_rem_x} + {1'b0, r_abs_dx};
    assign w_sum_y   = {1'b0, r_rem_y} + {1'b0, r_abs_dy};
    assign w_dif_x   = w_sum_x - {1'b0, r_span};
    assign w_dif_y   = w_sum_y - {1'b0, r_span};
    assign w_carry_x = w_sum_x >= {1'b0, r_span};
    assign w_carry_y = w_sum_y >= {1'b0, r_span};

    always_comb begin
        n_rem_x = w_carry_x ? w_dif_x[CB-1:0] : w_sum_x[CB-1:0];
        n_rem_y = w_carry_y ? w_dif_y[CB-1:0] : w_sum_y[CB-1:0];
        n_cur_x = r_cur_x;
        n_cur_y = r_cur_y;
        if (w_carry_x) begin
            n_cur_x = r_neg_x ? r_cur_x - CB'(1) : r_cur_x + CB'(1);
        end
        if (w_carry_y) begin
            n_cur_y = r_neg_y ? r_cur_y - CB'(1) : r_cur_y + CB'(1);
        end
    end

    assign o_stat.last = (r_step == r_span);

    // clip and address of the current point
    assign w_in_x = !r_cur_x[CB-1] &&
                    (cdlr_pkg::CMP_BITS'(r_cur_x) < cdlr_pkg::CMP_BITS'(r_width));
    assign w_in_y = !r_cur_y[CB-1] &&
                    (cdlr_pkg::CMP_BITS'(r_cur_y) < cdlr_pkg::CMP_BITS'(r_height));
    assign w_inside   = w_in_x & w_in_y;
    assign w_prod     = cdlr_pkg::PROD_BITS'(r_width) * cdlr_pkg::PROD_BITS'(r_cur_y);
    assign w_addr_sum = {1'b0, w_prod} + cdlr_pkg::SUM_BITS'(r_cur_x);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= cdlr_pkg::WIDTH_RESET;
            r_height <= cdlr_pkg::HEIGHT_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == cdlr_pkg::CFG_WIDTH) begin
                r_width <= i_cfg_data;
            end
            if (i_cfg_idx == cdlr_pkg::CFG_HEIGHT) begin
                r_height <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cur_x  <= i_start_x;
            r_cur_y  <= i_start_y;
            r_abs_dx <= w_ax[CB-1:0];
            r_abs_dy <= w_ay[CB-1:0];
            r_neg_x  <= w_dx[CB];
            r_neg_y  <= w_dy[CB];
            r_rem_x  <= '0;
            r_rem_y  <= '0;
            r_span   <= (w_ax > w_ay) ? w_ax[CB-1:0] : w_ay[CB-1:0];
            r_step   <= '0;
            r_colour <= i_line_colour;
        end else if (i_cmd.emit && !o_stat.last) begin
            r_cur_x <= n_cur_x;
            r_cur_y <= n_cur_y;
            r_rem_x <= n_rem_x;
            r_rem_y <= n_rem_y;
            r_step  <= r_step + CB'(1);
        end
    end

    // output word
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_pixel_x       <= r_cur_x;
            o_pixel_y       <= r_cur_y;
            o_pixel_address <= w_inside ? w_addr_sum[cdlr_pkg::ADDR_BITS-1:0] : '0;
            o_pixel_value   <= r_colour;
            o_inside_res    <= w_inside;
            o_last          <= o_stat.last;
        end
    end

`ifndef ASSERT_OFF
    a_step_bounded: assert property (@(posedge i_clk)
        (i_cmd.emit && !o_stat.last && !i_cmd.load) |=> (r_step <= r_span))
        else $error("step index ran past span");
    a_rem_bounded: assert property (@(posedge i_clk)
        (i_cmd.emit && !o_stat.last && !i_cmd.load) |=>
            ((r_rem_x < r_span) && (r_rem_y < r_span)))
        else $error("remainder not below span");
    a_outside_zero_addr: assert property (@(posedge i_clk)
        (i_cmd.emit && !w_inside) |=> (o_pixel_address == '0))
        else $error("address given for clipped point");
`endif

endmodule

// ----- sv/clipped_dda_line_rasterizer_unit.sv -----
// clipped_dda_line_rasterizer_unit: top level of the clipped dda line rasterizer
// depends on cdlr_pkg, cdlr_ctrl and cdlr_datapath
//
//  channel | handshake                | word
//  --------+--------------------------+---------------------------------------------
//  in      | i_in_valid / o_in_stall  | kind, start/end x,y, line_colour
//  out     | o_out_valid / i_out_stall| pixel x,y, address, value, inside, last
//  cfg     | i_cfg_we                 | i_cfg_idx, i_cfg_data (width, height)
//
// one input word per cycle while o_in_stall is low; a tick's pixel is presented in the cycle after acceptance
// the next point comes from a one-step quotient/remainder update per axis
// address uses one 13x16 multiply between the point and output registers
// o_in_stall is high only while a finished word is held by i_out_stall
// synchronous active-low reset: no line active, width 640, height 480
module clipped_dda_line_rasterizer_unit (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [cdlr_pkg::CFG_IDX_BITS-1:0]      i_cfg_idx,
    input  logic [cdlr_pkg::REG_BITS-1:0]          i_cfg_data,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic                                   i_kind,
    input  logic signed [cdlr_pkg::COORD_BITS-1:0] i_start_x,
    input  logic signed [cdlr_pkg::COORD_BITS-1:0] i_start_y,
    input  logic signed [cdlr_pkg::COORD_BITS-1:0] i_end_x,
    input  logic signed [cdlr_pkg::COORD_BITS-1:0] i_end_y,
    input  logic [cdlr_pkg::COLOUR_BITS-1:0]       i_line_colour,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic signed [cdlr_pkg::COORD_BITS-1:0] o_pixel_x,
    output logic signed [cdlr_pkg::COORD_BITS-1:0] o_pixel_y,
    output logic [cdlr_pkg::ADDR_BITS-1:0]         o_pixel_address,
    output logic [cdlr_pkg::COLOUR_BITS-1:0]       o_pixel_value,
    output logic                                   o_inside_res,
    output logic                                   o_last
);

    cdlr_pkg::t_cmd  w_cmd;
    cdlr_pkg::t_stat w_stat;

    cdlr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_kind      (i_kind),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd),
        .i_stat      (w_stat)
    );

    cdlr_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_start_x       (i_start_x),
        .i_start_y       (i_start_y),
        .i_end_x         (i_end_x),
        .i_end_y         (i_end_y),
        .i_line_colour   (i_line_colour),
        .o_pixel_x       (o_pixel_x),
        .o_pixel_y       (o_pixel_y),
        .o_pixel_address (o_pixel_address),
        .o_pixel_value   (o_pixel_value),
        .o_inside_res    (o_inside_res),
        .o_last          (o_last)
    );

endmodule
